// File: rtl/core/apt_pkg.sv
package apt_pkg;

    // default timer width in bits
    localparam int TIME_BITS_DEF = 24;

    // widths of the item fields and registers
    localparam int EL_W    = 16;
    localparam int LOOP_W  = 16;
    localparam int LVL_W   = 24;
    localparam int TOTAL_W = 17;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 3;

    // phase codes
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_LIGHT    = 4'd1,
        PH_MEDIUM   = 4'd2,
        PH_HIGH     = 4'd3,
        PH_PEAK     = 4'd4,
        PH_DECAY    = 4'd5,
        PH_SLEEP    = 4'd6,
        PH_LINKERR  = 4'd7,
        PH_FALLBACK = 4'd8
    } t_phase;

    // scene codes
    localparam logic [1:0] SC_NORMAL   = 2'd0;
    localparam logic [1:0] SC_SLEEP    = 2'd1;
    localparam logic [1:0] SC_LINKERR  = 2'd2;
    localparam logic [1:0] SC_FALLBACK = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_LOOP_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_TYP_MEDIUM   = 3'd1;
    localparam logic [2:0] CFG_TYP_HIGH     = 3'd2;
    localparam logic [2:0] CFG_TYP_PEAK     = 3'd3;
    localparam logic [2:0] CFG_DEC_MEDIUM   = 3'd4;
    localparam logic [2:0] CFG_DEC_LIGHT    = 3'd5;
    localparam logic [2:0] CFG_DEC_IDLE     = 3'd6;
    localparam logic [2:0] CFG_SLEEP        = 3'd7;

    // configuration set
    typedef struct packed {
        logic [LOOP_W-1:0] loop_period;
        logic [LVL_W-1:0]  typ_medium;
        logic [LVL_W-1:0]  typ_high;
        logic [LVL_W-1:0]  typ_peak;
        logic [LVL_W-1:0]  dec_medium;
        logic [LVL_W-1:0]  dec_light;
        logic [LVL_W-1:0]  dec_idle;
        logic [LVL_W-1:0]  sleep;
    } t_cfg;

    // sequencer states
    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_WAIT = 2'd1,
        SQ_DONE = 2'd2
    } t_seq_state;

endpackage

// File: rtl/core/activity_phase_tracker_unit.sv
// Activity phase tracker.
// One input item per display tick on the s_axis channel: elapsed ms, scene,
// typing flag and display side. Each item yields exactly one result on the
// m_axis channel: phase, frame-wanted flag, tick count and scene-entry flag.
// The user must write registers through the i_cfg_* port only while no item is
// in flight; the block does not enforce this. A write lands at the clock edge
// where i_cfg_we is high. The loop accumulator remainder comes from a
// restoring remainder unit that retires one of the 17 dividend bits per
// cycle; the sequencer waits in SQ_WAIT for its done flag, then commits
// the result from SQ_DONE. A new item is not taken before the last one is
// through; s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new item is taken while a
// finished result still waits. If the receiver stalls with a result already
// held, the next item waits at its final step until the register frees.
// Reset (synchronous, active low) returns the phase to idle, clears timers,
// accumulator and tick count, and loads the register defaults.
// A change of side clears all tracking state before that tick is processed.
module activity_phase_tracker_unit #(
    parameter int TIME_BITS = apt_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // elapsed[15:0], scene[17:16], typing_active[18], side[19], zero[23:20]
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // phase_now[3:0], frame_wanted[4], tick_count[20:5], scene_entered[21], zero[23:22]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    apt_pkg::t_cfg                  r_cfg;
    apt_pkg::t_seq_state            r_state, n_state;
    apt_pkg::t_phase                r_phase;
    logic [1:0]                     r_scene_reg;
    logic                           r_side_reg;
    logic [TIME_BITS-1:0]           r_typ, r_dec, r_idle;
    logic [apt_pkg::LOOP_W-1:0]     r_loop;
    logic [apt_pkg::CNT_W-1:0]      r_frame;

    // latched item
    logic [apt_pkg::EL_W-1:0]       r_el;
    logic [1:0]                     r_scene_in;
    logic                           r_typing_in;
    logic [apt_pkg::TOTAL_W-1:0]    r_total;

    // output register
    logic [23:0]                    r_out_data;
    logic                           r_out_valid;

    logic                           w_accept;
    logic                           w_commit;
    logic                           w_side_chg;
    logic [apt_pkg::TOTAL_W-1:0]    w_total;
    logic                           w_mod_done;
    logic [apt_pkg::LOOP_W-1:0]     w_rem;
    apt_pkg::t_phase                w_phase;
    logic [TIME_BITS-1:0]           w_typ, w_dec, w_idle;
    logic [apt_pkg::LOOP_W-1:0]     w_loop;
    logic                           w_want, w_changed;
    logic [apt_pkg::CNT_W-1:0]      w_frame;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_side_chg = (s_axis_tdata[19] != r_side_reg);
    // accumulator sum; a side change clears the accumulator first
    assign w_total    = apt_pkg::TOTAL_W'(w_side_chg ? '0 : r_loop) +
                        apt_pkg::TOTAL_W'(s_axis_tdata[15:0]);
    assign w_frame    = r_frame + 1'b1;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apt_pkg::SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_commit      = 1'b0;
        case (r_state)
            apt_pkg::SQ_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = apt_pkg::SQ_WAIT;
                end
            end
            apt_pkg::SQ_WAIT: begin
                if (w_mod_done) begin
                    n_state = apt_pkg::SQ_DONE;
                end
            end
            apt_pkg::SQ_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_commit = 1'b1;
                    n_state  = apt_pkg::SQ_IDLE;
                end
            end
            default: n_state = apt_pkg::SQ_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_period <= 16'd1000;
            r_cfg.typ_medium  <= 24'd1000;
            r_cfg.typ_high    <= 24'd2000;
            r_cfg.typ_peak    <= 24'd4000;
            r_cfg.dec_medium  <= 24'd2000;
            r_cfg.dec_light   <= 24'd4000;
            r_cfg.dec_idle    <= 24'd6000;
            r_cfg.sleep       <= 24'd30000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                apt_pkg::CFG_LOOP_PERIOD: r_cfg.loop_period <= i_cfg_data[15:0];
                apt_pkg::CFG_TYP_MEDIUM:  r_cfg.typ_medium  <= i_cfg_data;
                apt_pkg::CFG_TYP_HIGH:    r_cfg.typ_high    <= i_cfg_data;
                apt_pkg::CFG_TYP_PEAK:    r_cfg.typ_peak    <= i_cfg_data;
                apt_pkg::CFG_DEC_MEDIUM:  r_cfg.dec_medium  <= i_cfg_data;
                apt_pkg::CFG_DEC_LIGHT:   r_cfg.dec_light   <= i_cfg_data;
                apt_pkg::CFG_DEC_IDLE:    r_cfg.dec_idle    <= i_cfg_data;
                apt_pkg::CFG_SLEEP:       r_cfg.sleep       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latch the item on acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_el        <= s_axis_tdata[15:0];
            r_scene_in  <= s_axis_tdata[17:16];
            r_typing_in <= s_axis_tdata[18];
            r_total     <= w_total;
        end
    end

    // tracking state: side change clears at acceptance, update at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= apt_pkg::PH_IDLE;
            r_scene_reg <= apt_pkg::SC_NORMAL;
            r_side_reg  <= 1'b0;
            r_typ       <= '0;
            r_dec       <= '0;
            r_idle      <= '0;
            r_loop      <= '0;
            r_frame     <= '0;
        end else if (w_accept && w_side_chg) begin
            r_phase     <= apt_pkg::PH_IDLE;
            r_scene_reg <= apt_pkg::SC_NORMAL;
            r_side_reg  <= s_axis_tdata[19];
            r_typ       <= '0;
            r_dec       <= '0;
            r_idle      <= '0;
            r_loop      <= '0;
            r_frame     <= '0;
        end else if (w_commit) begin
            r_phase     <= w_phase;
            r_scene_reg <= r_scene_in;
            r_typ       <= w_typ;
            r_dec       <= w_dec;
            r_idle      <= w_idle;
            r_loop      <= w_loop;
            r_frame     <= w_frame;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= {2'b00, w_changed, w_frame, w_want, w_phase};
        end
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tvalid = r_out_valid;

    apt_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_total),
        .i_divisor  (r_cfg.loop_period),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    apt_phase #(
        .TIME_BITS (TIME_BITS)
    ) u_phase (
        .i_cfg       (r_cfg),
        .i_phase     (r_phase),
        .i_scene_reg (r_scene_reg),
        .i_scene     (r_scene_in),
        .i_typing    (r_typing_in),
        .i_el        (r_el),
        .i_total     (r_total),
        .i_rem       (w_rem),
        .i_loop      (r_loop),
        .i_typ       (r_typ),
        .i_dec       (r_dec),
        .i_idle      (r_idle),
        .o_phase     (w_phase),
        .o_typ       (w_typ),
        .o_dec       (w_dec),
        .o_idle      (w_idle),
        .o_loop      (w_loop),
        .o_want      (w_want),
        .o_changed   (w_changed)
    );

endmodule

// File: rtl/core/apt_mod.sv
// Restoring remainder unit: one dividend bit per cycle
module apt_mod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [apt_pkg::TOTAL_W-1:0]    i_dividend,
    input  logic [apt_pkg::LOOP_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [apt_pkg::LOOP_W-1:0]     o_rem
);

    localparam int CW = $clog2(apt_pkg::TOTAL_W + 1);

    logic [apt_pkg::TOTAL_W-1:0] r_num;
    logic [apt_pkg::LOOP_W-1:0]  r_rem;
    logic [CW-1:0]               r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [apt_pkg::LOOP_W:0]    w_shift;
    logic [apt_pkg::LOOP_W:0]    w_sub;

    // shift in next bit, trial subtract
    always_comb begin
        w_shift = {r_rem, r_num[apt_pkg::TOTAL_W-1]};
        w_sub   = w_shift - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(apt_pkg::TOTAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[apt_pkg::TOTAL_W-2:0], 1'b0};
            if (w_shift >= {1'b0, i_divisor}) begin
                r_rem <= w_sub[apt_pkg::LOOP_W-1:0];
            end else begin
                r_rem <= w_shift[apt_pkg::LOOP_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/core/apt_phase.sv
// Next-state logic for phase, timers and loop accumulator
module apt_phase #(
    parameter int TIME_BITS = apt_pkg::TIME_BITS_DEF
) (
    input  apt_pkg::t_cfg                  i_cfg,
    input  apt_pkg::t_phase                i_phase,
    input  logic [1:0]                     i_scene_reg,
    input  logic [1:0]                     i_scene,
    input  logic                           i_typing,
    input  logic [apt_pkg::EL_W-1:0]       i_el,
    input  logic [apt_pkg::TOTAL_W-1:0]    i_total,
    input  logic [apt_pkg::LOOP_W-1:0]     i_rem,
    input  logic [apt_pkg::LOOP_W-1:0]     i_loop,
    input  logic [TIME_BITS-1:0]           i_typ,
    input  logic [TIME_BITS-1:0]           i_dec,
    input  logic [TIME_BITS-1:0]           i_idle,
    output apt_pkg::t_phase                o_phase,
    output logic [TIME_BITS-1:0]           o_typ,
    output logic [TIME_BITS-1:0]           o_dec,
    output logic [TIME_BITS-1:0]           o_idle,
    output logic [apt_pkg::LOOP_W-1:0]     o_loop,
    output logic                           o_want,
    output logic                           o_changed
);

    localparam int CW = (TIME_BITS > apt_pkg::LVL_W) ? TIME_BITS : apt_pkg::LVL_W;

    logic [TIME_BITS:0]   w_typ_sum, w_dec_sum, w_idle_sum;
    logic [TIME_BITS-1:0] w_typ_sat, w_dec_sat, w_idle_sat;
    logic                 w_boundary;
    logic                 w_was_typing;

    // saturating timer adds
    always_comb begin
        w_typ_sum  = {1'b0, i_typ}  + (TIME_BITS+1)'(i_el);
        w_dec_sum  = {1'b0, i_dec}  + (TIME_BITS+1)'(i_el);
        w_idle_sum = {1'b0, i_idle} + (TIME_BITS+1)'(i_el);
        w_typ_sat  = w_typ_sum[TIME_BITS]  ? '1 : w_typ_sum[TIME_BITS-1:0];
        w_dec_sat  = w_dec_sum[TIME_BITS]  ? '1 : w_dec_sum[TIME_BITS-1:0];
        w_idle_sat = w_idle_sum[TIME_BITS] ? '1 : w_idle_sum[TIME_BITS-1:0];
    end

    always_comb begin
        // zero period: every tick is a boundary, accumulator held
        w_boundary   = (i_cfg.loop_period == '0) ||
                       (i_total >= apt_pkg::TOTAL_W'(i_cfg.loop_period));
        w_was_typing = (i_phase inside {[apt_pkg::PH_LIGHT:apt_pkg::PH_PEAK]});
        o_changed    = (i_scene_reg != i_scene);

        o_phase = i_phase;
        o_typ   = i_typ;
        o_dec   = i_dec;
        o_idle  = i_idle;
        o_loop  = (i_cfg.loop_period == '0) ? i_loop : i_rem;

        if (o_changed) begin
            o_typ  = '0;
            o_dec  = '0;
            o_idle = '0;
            o_loop = '0;
        end

        if (i_scene != apt_pkg::SC_NORMAL) begin
            case (i_scene)
                apt_pkg::SC_SLEEP:   o_phase = apt_pkg::PH_SLEEP;
                apt_pkg::SC_LINKERR: o_phase = apt_pkg::PH_LINKERR;
                default:             o_phase = apt_pkg::PH_FALLBACK;
            endcase
            o_typ  = '0;
            o_dec  = '0;
            o_idle = '0;
        end else if (i_typing) begin
            // climb with the typing time
            if (!w_was_typing) begin
                o_typ  = '0;
                o_loop = '0;
            end else begin
                o_typ = w_typ_sat;
            end
            o_dec  = '0;
            o_idle = '0;
            if (CW'(o_typ) >= CW'(i_cfg.typ_peak)) begin
                o_phase = apt_pkg::PH_PEAK;
            end else if (CW'(o_typ) >= CW'(i_cfg.typ_high)) begin
                o_phase = apt_pkg::PH_HIGH;
            end else if (CW'(o_typ) >= CW'(i_cfg.typ_medium)) begin
                o_phase = apt_pkg::PH_MEDIUM;
            end else begin
                o_phase = apt_pkg::PH_LIGHT;
            end
        end else if (w_was_typing || i_phase == apt_pkg::PH_DECAY) begin
            // step down towards idle at a loop boundary; peak and high both drop to medium
            o_typ  = '0;
            o_dec  = w_dec_sat;
            o_idle = '0;
            if ((i_phase == apt_pkg::PH_PEAK || i_phase == apt_pkg::PH_HIGH) &&
                CW'(w_dec_sat) >= CW'(i_cfg.dec_medium) && w_boundary) begin
                o_phase = apt_pkg::PH_MEDIUM;
            end else if (i_phase == apt_pkg::PH_MEDIUM &&
                         CW'(w_dec_sat) >= CW'(i_cfg.dec_light) && w_boundary) begin
                o_phase = apt_pkg::PH_LIGHT;
            end else if (i_phase == apt_pkg::PH_LIGHT &&
                         CW'(w_dec_sat) >= CW'(i_cfg.dec_idle) && w_boundary) begin
                o_phase = apt_pkg::PH_IDLE;
                o_dec   = '0;
            end else begin
                o_phase = i_phase;
            end
        end else if (i_phase == apt_pkg::PH_SLEEP) begin
            o_typ   = '0;
            o_dec   = '0;
            o_phase = apt_pkg::PH_SLEEP;
        end else begin
            // idle, count towards sleep
            o_typ   = '0;
            o_dec   = '0;
            o_idle  = w_idle_sat;
            o_phase = (CW'(w_idle_sat) >= CW'(i_cfg.sleep)) ? apt_pkg::PH_SLEEP
                                                             : apt_pkg::PH_IDLE;
        end

        o_want = (i_scene == apt_pkg::SC_NORMAL) && (o_phase != apt_pkg::PH_SLEEP) &&
                 (o_phase != apt_pkg::PH_LINKERR) && (o_phase != apt_pkg::PH_FALLBACK);
    end

endmodule
